FILE: hw/rtl/fpc_pkg.sv
// shared types and codes for the factorial / permutation / combination unit
package fpc_pkg;

	// operation select codes
	localparam logic [1:0] OP_FACT = 2'd0;
	localparam logic [1:0] OP_PERM = 2'd1;
	localparam logic [1:0] OP_COMB = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_RGTN = 2'd2;

	// widest argument the datapath supports
	localparam int ARG_EXT_W = 16;

	typedef struct packed {
		logic [1:0] op_select;
		logic [7:0] count_n;
		logic [7:0] count_r;
	} fpc_req_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
	} fpc_rsp_t;

endpackage

FILE: hw/rtl/factorial_permutation_combination.sv
// factorial, permutation and combination unit: top level with control sequencer
// n! multiplies in n factors, nPr r factors, and nCr k factors with an exact divide after each,
// with k = min(r, n-r); overflow cuts the loop short
// the loop runs on the bit-serial multiplier and the bit-serial exact divider
// one request at a time: busy high from the start transfer until done, results never stall
// async active-low reset returns the sequencer to idle; result is one-cycle done pulse
module factorial_permutation_combination import fpc_pkg::*; #(
	parameter int RESULT_BITS = 64,
	parameter int ARG_BITS    = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  fpc_req_t request,
	output logic     busy,
	output logic     done,
	output fpc_rsp_t result
);
	localparam int RB  = RESULT_BITS;
	localparam int AB  = ARG_BITS;
	localparam int P_W = RB + AB;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOP = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	localparam logic [RB-1:0] RES_MAX = {RB{1'b1}};

	logic [2:0]     state_q;
	logic [RB-1:0]  acc_q;     // running product
	logic [AB-1:0]  f_q;       // next factor
	logic [AB-1:0]  d_q;       // next divisor (combination only)
	logic [AB-1:0]  rem_q;     // factors still to apply
	logic           comb_q;
	fpc_rsp_t       result_q;

	// argument extraction: low ARG_BITS bits of each count
	logic [ARG_EXT_W-1:0] n_ext;
	logic [ARG_EXT_W-1:0] r_ext;
	logic [AB-1:0]        n_in;
	logic [AB-1:0]        r_in;
	logic [AB-1:0]        nr_in;
	logic [AB-1:0]        k_in;
	logic [AB-1:0]        base_in;

	assign n_ext   = ARG_EXT_W'(request.count_n);
	assign r_ext   = ARG_EXT_W'(request.count_r);
	assign n_in    = n_ext[AB-1:0];
	assign r_in    = r_ext[AB-1:0];
	assign nr_in   = n_in - r_in;
	assign k_in    = (r_in > nr_in) ? nr_in : r_in;   // symmetric choice of the shorter run
	assign base_in = n_in - k_in;

	// shared serial arithmetic
	logic           mul_start;
	logic           mul_done;
	logic [P_W-1:0] mul_p;
	logic           div_start;
	logic           div_done;
	logic [P_W-1:0] div_q;
	logic [P_W-1:0] stage_val;
	logic           stage_ovf;

	assign mul_start = (state_q == S_LOOP) && (rem_q != '0);
	assign div_start = (state_q == S_MUL) && mul_done && comb_q;

	// product (n! and nPr) or exact quotient (nCr) feeding the accumulator
	assign stage_val = (state_q == S_DIV) ? div_q : mul_p;
	assign stage_ovf = |stage_val[P_W-1:RB];

	fpc_mul #(
		.A_W(RB),
		.B_W(AB)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (acc_q),
		.b     (f_q),
		.done  (mul_done),
		.p     (mul_p)
	);

	fpc_div #(
		.N_W(P_W),
		.D_W(AB)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mul_p),
		.divisor (d_q),
		.done    (div_done),
		.quotient(div_q)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						priority if (request.op_select == OP_FACT) begin
							state_q <= S_LOOP;
						end else if (request.op_select == OP_PERM ||
							request.op_select == OP_COMB) begin
							state_q <= (r_in > n_in) ? S_OUT : S_LOOP;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_LOOP: begin
					if (rem_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						if (comb_q) begin
							state_q <= S_DIV;
						end else begin
							state_q <= stage_ovf ? S_OUT : S_LOOP;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= stage_ovf ? S_OUT : S_LOOP;
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					acc_q  <= RB'(1);
					d_q    <= AB'(1);
					comb_q <= (request.op_select == OP_COMB);
					priority if (request.op_select == OP_FACT) begin
						// n! is the falling product from n down to 1
						f_q   <= n_in;
						rem_q <= n_in;
					end else if (request.op_select == OP_PERM) begin
						f_q   <= n_in;
						rem_q <= r_in;
					end else begin
						f_q   <= base_in + 1'b1;
						rem_q <= k_in;
					end
					if ((request.op_select == OP_PERM || request.op_select == OP_COMB)
						&& (r_in > n_in)) begin
						result_q.value  <= '0;
						result_q.status <= ST_RGTN;
					end else begin
						// unused selector also lands here with zero and ok
						result_q.value  <= '0;
						result_q.status <= ST_OK;
					end
				end
			end
			S_LOOP: begin
				if (rem_q == '0) begin
					result_q.value  <= 64'(acc_q);
					result_q.status <= ST_OK;
				end
			end
			S_MUL: begin
				if (mul_done && !comb_q) begin
					if (stage_ovf) begin
						result_q.value  <= 64'(RES_MAX);
						result_q.status <= ST_OVF;
					end else begin
						acc_q <= stage_val[RB-1:0];
						f_q   <= f_q - 1'b1;
						rem_q <= rem_q - 1'b1;
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (stage_ovf) begin
						result_q.value  <= 64'(RES_MAX);
						result_q.status <= ST_OVF;
					end else begin
						acc_q <= stage_val[RB-1:0];
						f_q   <= f_q + 1'b1;
						d_q   <= d_q + 1'b1;
						rem_q <= rem_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_OUT);
	assign result = result_q;

	// result strobe lasts exactly one cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held for more than one cycle");

	// an r greater than n result always carries a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_RGTN) |-> (result.value == '0))
		else $error("r greater than n result with non-zero value");

	// overflow always saturates to the full range
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_OVF) |-> (result.value == 64'(RES_MAX)))
		else $error("overflow result not saturated");

	// the divider only ever runs on the combination path
	assert property (@(posedge clk) disable iff (!arst_n) div_start |-> comb_q)
		else $error("divider started outside combination");

endmodule

FILE: hw/rtl/fpc_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
module fpc_mul import fpc_pkg::*; #(
	parameter int A_W = 64,
	parameter int B_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] p
);
	localparam int P_W = A_W + B_W;
	localparam int C_W = $clog2(B_W + 1);

	logic           busy_q;
	logic           done_q;
	logic [C_W-1:0] cnt_q;
	logic [A_W-1:0] a_q;
	logic [B_W-1:0] b_q;
	logic [P_W-1:0] p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= C_W'(B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= {p_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : '0);
			b_q <= {b_q[B_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

FILE: hw/rtl/fpc_div.sv
// restoring bit-serial divider, one quotient bit per cycle
module fpc_div import fpc_pkg::*; #(
	parameter int N_W = 72,
	parameter int D_W = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);
	localparam int C_W = $clog2(N_W + 1);

	logic           busy_q;
	logic           done_q;
	logic [C_W-1:0] cnt_q;
	logic [N_W-1:0] qd_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] d_q;
	logic [D_W:0]   trial;
	logic [D_W:0]   diff;
	logic           ge;

	// shift in next dividend bit and try the subtraction
	assign trial = {rem_q, qd_q[N_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= C_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			qd_q  <= {qd_q[N_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = qd_q;

endmodule
